[hw/rtl/masked_window_average_blur_unit_defines.svh]
// Assertion macros shared by the blur unit RTL.
`ifndef MASKED_WINDOW_AVERAGE_BLUR_UNIT_DEFINES_SVH
`define MASKED_WINDOW_AVERAGE_BLUR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is high.
`define MWAB_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while reset is high.
`define MWAB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mwab_pkg.sv]
// Shared constants and types of the masked window average blur unit.
package mwab_pkg;

   localparam int MAX_WIDTH     = 256;
   localparam int MAX_HEIGHT    = 256;
   localparam int WINDOW_RADIUS = 20;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int CFG_W  = 9;
   localparam int CH_W   = 8;
   localparam int PIX_W  = 3 * CH_W;

   localparam int WIN_SIDE = 2 * WINDOW_RADIUS + 1;
   localparam int WIN_AREA = WIN_SIDE * WIN_SIDE;
   localparam int OFS_W    = $clog2(WINDOW_RADIUS + 1) + 1;
   localparam int D2_W     = $clog2(2 * WINDOW_RADIUS * WINDOW_RADIUS + 1);
   localparam int CNT_W    = $clog2(WIN_AREA + 1);
   localparam int SUM_W    = $clog2(WIN_AREA * ((1 << CH_W) - 1) + 1);
   localparam int DIV_W    = SUM_W + 1;
   localparam int STEP_W   = $clog2(DIV_W);

   // item kinds carried on req_tuser
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // register map of the csr_ channel
   localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
   localparam logic [1:0] REG_INNER_RADIUS_SQ = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[hw/rtl/mwab_divider.sv]
// Restoring divider, one quotient bit per cycle, shared by the three channels.
module mwab_divider import mwab_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [CNT_W-1:0]     divisor,
   output logic [CH_W-1:0]      quotient,
   output div_status_type       status
);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   // mean never exceeds the channel range, so the low bits carry the result
   assign quotient    = quo_ff[CH_W-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[hw/rtl/masked_window_average_blur_unit.sv]
// Top level of the masked window average blur unit: image memory, window walk, output.
//
// The unit stores an RGB image (8 bits per channel, up to 256 x 256) and
// answers blur requests. A beat on req_ with tuser low writes one pixel and
// returns nothing (pixels outside the configured image
// are dropped). A beat with tuser high asks for the pixel at (col,row) and
// returns one rsp_ beat: the mean colour of all in-image pixels of the 41x41
// window around it whose squared distance from the centre is at least
// inner_radius_sq, rounded to nearest with halves up. When no pixel
// qualifies the colours are zero and rsp_tuser (empty_window) is high.
// During a read the window walk issues one image-memory
// read per cycle over all 1681 window positions (the single read port of the
// image memory sets this), then one divider produces the three channel means
// in turn at one quotient bit per cycle. req_tready is low
// for the whole read; the result waits in an output register, so the next
// item is taken while rsp_ is stalled. Pixels never written since reset read
// back as arbitrary data. CSR writes are taken in any cycle (csr_ready is
// always high) and must be issued only while the unit is idle.
`include "masked_window_average_blur_unit_defines.svh"

module masked_window_average_blur_unit import mwab_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [39:0]             req_tdata,   // col, row, in_red, in_green, in_blue
   input  logic                    req_tuser,   // func
   // result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [PIX_W-1:0]        rsp_tdata,   // out_red, out_green, out_blue
   output logic                    rsp_tuser,   // empty_window
   // register write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [CFG_W-1:0]        csr_data
);

   localparam int CX_W  = CFG_W + 1;
   localparam int CMP_W = (D2_W > CFG_W) ? D2_W : CFG_W;

   localparam logic signed [OFS_W-1:0] OFS_MAX = OFS_W'(WINDOW_RADIUS);
   localparam logic signed [OFS_W-1:0] OFS_MIN = -OFS_MAX;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_PREP,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } chan_type;

   // configuration
   logic [CFG_W-1:0] cfg_width_ff, cfg_width_in;
   logic [CFG_W-1:0] cfg_height_ff, cfg_height_in;
   logic [CFG_W-1:0] cfg_radius_ff, cfg_radius_in;
   logic [CFG_W-1:0] eff_w, eff_h;

   // sequencer and walk
   state_type                state_ff, state_in;
   chan_type                 chan_ff, chan_in;
   logic [COL_W-1:0]         center_col_ff, center_col_in;
   logic [ROW_W-1:0]         center_row_ff, center_row_in;
   logic signed [OFS_W-1:0]  dx_ff, dx_in;
   logic signed [OFS_W-1:0]  dy_ff, dy_in;
   logic                     acc_en_ff, acc_en_in;

   // accumulators
   logic [SUM_W-1:0] sum_r_ff, sum_r_in;
   logic [SUM_W-1:0] sum_g_ff, sum_g_in;
   logic [SUM_W-1:0] sum_b_ff, sum_b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // channel results and output register
   logic [CH_W-1:0]  res_r_ff, res_r_in;
   logic [CH_W-1:0]  res_g_ff, res_g_in;
   logic [CH_W-1:0]  res_b_ff, res_b_in;
   logic             empty_ff, empty_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [PIX_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic             rsp_tuser_ff, rsp_tuser_in;

   // image memory
   logic [PIX_W-1:0]  image_mem [MAX_WIDTH*MAX_HEIGHT];
   logic [PIX_W-1:0]  ram_rd_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [PIX_W-1:0]  wr_pix;
   logic              ram_we;

   // request decode
   logic             req_accept;
   logic [COL_W-1:0] req_col;
   logic [ROW_W-1:0] req_row;

   // window position
   logic [CX_W-1:0]      win_x, win_y;
   logic                 x_ok, y_ok, ring_ok;
   logic [2*OFS_W-1:0]   dx_sq, dy_sq;
   logic [D2_W-1:0]      d2;
   logic                 walk_last;

   // divider hookup
   logic             div_start;
   chan_type         div_chan;
   logic [DIV_W-1:0] div_dividend;
   logic [CH_W-1:0]  div_quotient;
   div_status_type   div_status;

   // oversized image dimensions clamp to the memory size
   assign eff_w = (cfg_width_ff > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : cfg_width_ff;
   assign eff_h = (cfg_height_ff > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : cfg_height_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_col    = req_tdata[COL_W-1:0];
   assign req_row    = req_tdata[COL_W +: ROW_W];

   // pixel write: stored as {red, green, blue}
   assign wr_addr = {req_row, req_col};
   assign wr_pix  = {req_tdata[COL_W+ROW_W +: CH_W],
                     req_tdata[COL_W+ROW_W+CH_W +: CH_W],
                     req_tdata[COL_W+ROW_W+2*CH_W +: CH_W]};
   assign ram_we  = req_accept && (req_tuser == FUNC_WRITE)
                    && (CFG_W'(req_col) < eff_w) && (CFG_W'(req_row) < eff_h);

   // window position under the walk counters; negatives wrap to the top bit
   assign win_x = CX_W'(center_col_ff) + CX_W'(dx_ff);
   assign win_y = CX_W'(center_row_ff) + CX_W'(dy_ff);
   assign x_ok  = !win_x[CX_W-1] && (win_x[CFG_W-1:0] < eff_w);
   assign y_ok  = !win_y[CX_W-1] && (win_y[CFG_W-1:0] < eff_h);

   assign dx_sq   = (2*OFS_W)'(dx_ff) * (2*OFS_W)'(dx_ff);
   assign dy_sq   = (2*OFS_W)'(dy_ff) * (2*OFS_W)'(dy_ff);
   assign d2      = D2_W'(dx_sq) + D2_W'(dy_sq);
   assign ring_ok = CMP_W'(d2) >= CMP_W'(cfg_radius_ff);

   assign rd_addr   = {win_y[ROW_W-1:0], win_x[COL_W-1:0]};
   assign walk_last = (dx_ff == OFS_MAX) && (dy_ff == OFS_MAX);

   // image memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ram_we) begin
         image_mem[wr_addr] <= wr_pix;
      end
      ram_rd_ff <= image_mem[rd_addr];
   end

   // round to nearest: (sum + count/2) / count
   always_comb begin
      case (div_chan)
         CH_RED:   div_dividend = DIV_W'(sum_r_ff) + DIV_W'(cnt_ff >> 1);
         CH_GREEN: div_dividend = DIV_W'(sum_g_ff) + DIV_W'(cnt_ff >> 1);
         CH_BLUE:  div_dividend = DIV_W'(sum_b_ff) + DIV_W'(cnt_ff >> 1);
         default:  div_dividend = '0;
      endcase
   end

   mwab_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_comb begin
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      cfg_radius_in = cfg_radius_ff;
      state_in      = state_ff;
      chan_in       = chan_ff;
      center_col_in = center_col_ff;
      center_row_in = center_row_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      acc_en_in     = 1'b0;
      sum_r_in      = sum_r_ff;
      sum_g_in      = sum_g_ff;
      sum_b_in      = sum_b_ff;
      cnt_in        = cnt_ff;
      res_r_in      = res_r_ff;
      res_g_in      = res_g_ff;
      res_b_in      = res_b_ff;
      empty_in      = empty_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      div_start     = 1'b0;
      div_chan      = CH_RED;

      // register writes; unknown indexes fall through
      if (csr_valid) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:     cfg_width_in  = csr_data;
            REG_IMAGE_HEIGHT:    cfg_height_in = csr_data;
            REG_INNER_RADIUS_SQ: cfg_radius_in = csr_data;
            default: ;
         endcase
      end

      // add the pixel fetched in the previous cycle
      if (acc_en_ff) begin
         sum_r_in = sum_r_ff + SUM_W'(ram_rd_ff[2*CH_W +: CH_W]);
         sum_g_in = sum_g_ff + SUM_W'(ram_rd_ff[CH_W +: CH_W]);
         sum_b_in = sum_b_ff + SUM_W'(ram_rd_ff[0 +: CH_W]);
         cnt_in   = cnt_ff + 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == FUNC_READ)) begin
               center_col_in = req_col;
               center_row_in = req_row;
               dx_in         = OFS_MIN;
               dy_in         = OFS_MIN;
               sum_r_in      = '0;
               sum_g_in      = '0;
               sum_b_in      = '0;
               cnt_in        = '0;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            // fetch this position; count it next cycle if it qualifies
            acc_en_in = x_ok && y_ok && ring_ok;
            if (walk_last) begin
               state_in = ST_DRAIN;
            end else if (dx_ff == OFS_MAX) begin
               dx_in = OFS_MIN;
               dy_in = dy_ff + 1'b1;
            end else begin
               dx_in = dx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            if (cnt_ff == '0) begin
               res_r_in = '0;
               res_g_in = '0;
               res_b_in = '0;
               empty_in = 1'b1;
               state_in = ST_OUTPUT;
            end else begin
               empty_in  = 1'b0;
               chan_in   = CH_RED;
               div_start = 1'b1;
               div_chan  = CH_RED;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               case (chan_ff)
                  CH_RED: begin
                     res_r_in  = div_quotient;
                     chan_in   = CH_GREEN;
                     div_chan  = CH_GREEN;
                     div_start = 1'b1;
                  end
                  CH_GREEN: begin
                     res_g_in  = div_quotient;
                     chan_in   = CH_BLUE;
                     div_chan  = CH_BLUE;
                     div_start = 1'b1;
                  end
                  default: begin
                     res_b_in = div_quotient;
                     state_in = ST_OUTPUT;
                  end
               endcase
            end
         end
         ST_OUTPUT: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {res_b_ff, res_g_ff, res_r_ff};
               rsp_tuser_in  = empty_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         acc_en_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         cfg_width_ff  <= CFG_W'(256);
         cfg_height_ff <= CFG_W'(256);
         cfg_radius_ff <= '0;
      end else begin
         state_ff      <= state_in;
         acc_en_ff     <= acc_en_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         cfg_width_ff  <= cfg_width_in;
         cfg_height_ff <= cfg_height_in;
         cfg_radius_ff <= cfg_radius_in;
      end
      chan_ff       <= chan_in;
      center_col_ff <= center_col_in;
      center_row_ff <= center_row_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      sum_r_ff      <= sum_r_in;
      sum_g_ff      <= sum_g_in;
      sum_b_ff      <= sum_b_in;
      cnt_ff        <= cnt_in;
      res_r_ff      <= res_r_in;
      res_g_ff      <= res_g_in;
      res_b_ff      <= res_b_in;
      empty_ff      <= empty_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign csr_ready  = 1'b1;

   `MWAB_ASSERT_IMPL(a_div_start_free, div_start, !div_status.busy, "divider restarted while busy")
   `MWAB_ASSERT_IMPL(a_div_nonzero, div_start, cnt_ff != '0, "divide started with zero count")
   `MWAB_ASSERT_IMPL(a_cnt_bound, state_ff == ST_PREP, cnt_ff <= CNT_W'(WIN_AREA), "count above window area")
   `MWAB_ASSERT_IMPL(a_empty_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "empty window with colour")
   `MWAB_ASSERT_NEXT(a_read_starts_clear, req_accept && req_tuser == FUNC_READ, cnt_ff == '0 && state_ff == ST_WALK, "read started with stale count")

endmodule
